// ===== src/lms_pkg.sv =====
// shared types, codes and helpers for the led matrix shadow updater
package lms_pkg;

    // item kind
    typedef enum logic {
        FUNC_PIXEL  = 1'b0,
        FUNC_COLUMN = 1'b1
    } t_func;

    // color codes
    typedef enum logic [1:0] {
        COLOR_GREEN  = 2'd0,
        COLOR_RED    = 2'd1,
        COLOR_ORANGE = 2'd2,
        COLOR_BLACK  = 2'd3
    } t_color;

    // top dot of a column byte
    localparam logic [7:0] DOT_TOP = 8'h80;

    // one input item as held in the input register
    typedef struct packed {
        t_func       func;
        logic [4:0]  column;
        logic [3:0]  pixel_row;
        logic        band;
        t_color      color;
        logic [7:0]  column_bits;
    } t_item;

    // one nibble write command
    typedef struct packed {
        logic [1:0] chip_index;
        logic [5:0] ram_address;
        logic [3:0] nibble;
        logic       last;
    } t_result;

    // band an item touches
    function automatic logic item_band(input t_item item);
        logic b;
        b = (item.func == FUNC_COLUMN) ? item.band : item.pixel_row[3];
        return b;
    endfunction

endpackage

// ===== src/led_matrix_shadow_updater.sv =====
// Shadow framebuffer for a bicolor LED matrix that emits nibble writes for changed bytes.
// The first write of an item is offered once the item has left the input register and
// been loaded into the result buffer. An item makes 0, 2 or 4 writes; the single result
// port hands out one write a cycle unless i_out_stall holds it, which sets the item rate.
// Reset: synchronous active low; per-row flags clear at once so the whole shadow reads
// as zero right after reset, with no clearing pass.
module led_matrix_shadow_updater #(
    parameter int COLUMNS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_func,
    input  logic [4:0] i_column,
    input  logic [3:0] i_pixel_row,
    input  logic       i_band,
    input  logic [1:0] i_color,
    input  logic [7:0] i_column_bits,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_chip_index,
    output logic [5:0] o_ram_address,
    output logic [3:0] o_nibble,
    output logic       o_last
);

    localparam int         DEPTH  = COLUMNS * 2;
    localparam int         RW     = $clog2(DEPTH);
    localparam logic [6:0] COLS_W = 7'(COLUMNS);

    lms_pkg::t_item   in_item;
    lms_pkg::t_item   r_a;
    logic             r_a_valid;
    logic             accept;
    logic             go;
    logic             in_range;
    logic             buf_free;
    logic [RW-1:0]    rd_row;
    logic [RW-1:0]    a_row;
    logic [15:0]      rd_data;
    logic [7:0]       new_red;
    logic [7:0]       new_green;
    lms_pkg::t_result res [4];
    logic [2:0]       count;
    lms_pkg::t_result out_res;

    // input item and handshake
    always_comb begin
        in_item = '{func: lms_pkg::t_func'(i_func), column: i_column,
                    pixel_row: i_pixel_row, band: i_band,
                    color: lms_pkg::t_color'(i_color), column_bits: i_column_bits};
        go         = r_a_valid && buf_free;
        o_in_stall = r_a_valid && !go;
        accept     = i_in_valid && !o_in_stall;
        in_range   = ({2'b00, r_a.column} < COLS_W);
        a_row      = RW'({r_a.column, lms_pkg::item_band(r_a)});
        rd_row     = accept ? RW'({i_column, lms_pkg::item_band(in_item)}) : a_row;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (go) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a <= in_item;
        end
    end

    // shadow store
    lms_store #(
        .DEPTH (DEPTH),
        .RW    (RW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_row  (rd_row),
        .i_wr_en   (go && in_range),
        .i_wr_row  (a_row),
        .i_wr_data ({new_red, new_green}),
        .o_rd_data (rd_data)
    );

    // byte update and write list
    lms_update u_update (
        .i_item      (r_a),
        .i_red       (rd_data[15:8]),
        .i_green     (rd_data[7:0]),
        .o_new_red   (new_red),
        .o_new_green (new_green),
        .o_res       (res),
        .o_count     (count)
    );

    // result buffer
    lms_result_buf u_result_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (go),
        .i_res       (res),
        .i_count     (in_range ? count : 3'd0),
        .o_free      (buf_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (out_res)
    );

    assign o_chip_index  = out_res.chip_index;
    assign o_ram_address = out_res.ram_address;
    assign o_nibble      = out_res.nibble;
    assign o_last        = out_res.last;

endmodule

// ===== src/lms_store.sv =====
// shadow store: one row per column and band holding the red and green bytes
module lms_store #(
    parameter int DEPTH = 64,
    parameter int RW    = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [RW-1:0] i_rd_row,
    input  logic          i_wr_en,
    input  logic [RW-1:0] i_wr_row,
    input  logic [15:0]   i_wr_data,
    output logic [15:0]   o_rd_data
);

    logic [15:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_written;
    logic [15:0]    r_rd_data;
    logic           r_rd_ok;
    logic [RW-1:0]  r_rd_row;
    logic           r_fwd_valid;
    logic [RW-1:0]  r_fwd_row;
    logic [15:0]    r_fwd_data;

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_row];
        r_rd_row  <= i_rd_row;
    end

    // per-row written flags, cleared at reset so the shadow reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_ok   <= 1'b0;
        end else begin
            r_rd_ok <= r_written[i_rd_row];
            if (i_wr_en) begin
                r_written[i_wr_row] <= 1'b1;
            end
        end
    end

    // latest write, forwarded over a read that raced it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (i_wr_en) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_fwd_row  <= i_wr_row;
            r_fwd_data <= i_wr_data;
        end
    end

    // read data seen by the update stage
    always_comb begin
        if (r_fwd_valid && (r_fwd_row == r_rd_row)) begin
            o_rd_data = r_fwd_data;
        end else if (r_rd_ok) begin
            o_rd_data = r_rd_data;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

// ===== src/lms_update.sv =====
// new color bytes and the nibble writes for the bytes that change
module lms_update (
    input  lms_pkg::t_item   i_item,
    input  logic [7:0]       i_red,
    input  logic [7:0]       i_green,
    output logic [7:0]       o_new_red,
    output logic [7:0]       o_new_green,
    output lms_pkg::t_result o_res [4],
    output logic [2:0]       o_count
);

    logic       band;
    logic [1:0] chip;
    logic [7:0] mask;
    logic       red_first;
    logic [7:0] old1, old2, new1, new2;
    logic       c1, c2;
    lms_pkg::t_result p1 [2];
    lms_pkg::t_result p2 [2];

    // new byte values per color and kind
    always_comb begin
        band = lms_pkg::item_band(i_item);
        chip = {band, i_item.column[4]};
        mask = lms_pkg::DOT_TOP >> i_item.pixel_row[2:0];
        o_new_red   = i_red;
        o_new_green = i_green;
        red_first   = 1'b0;
        if (i_item.func == lms_pkg::FUNC_PIXEL) begin
            case (i_item.color)
                lms_pkg::COLOR_GREEN: begin
                    o_new_green = i_green | mask;
                    o_new_red   = i_red & ~mask;
                end
                lms_pkg::COLOR_RED: begin
                    red_first   = 1'b1;
                    o_new_red   = i_red | mask;
                    o_new_green = i_green & ~mask;
                end
                lms_pkg::COLOR_ORANGE: begin
                    o_new_green = i_green | mask;
                    o_new_red   = i_red | mask;
                end
                default: begin
                    red_first   = 1'b1;
                    o_new_red   = i_red & ~mask;
                    o_new_green = i_green & ~mask;
                end
            endcase
        end else begin
            case (i_item.color)
                lms_pkg::COLOR_GREEN: begin
                    o_new_green = i_item.column_bits;
                    o_new_red   = 8'h00;
                end
                lms_pkg::COLOR_RED: begin
                    red_first   = 1'b1;
                    o_new_red   = i_item.column_bits;
                    o_new_green = 8'h00;
                end
                lms_pkg::COLOR_ORANGE: begin
                    o_new_green = i_item.column_bits;
                    o_new_red   = i_item.column_bits;
                end
                default: begin
                    o_new_red   = i_red;
                    o_new_green = i_green;
                end
            endcase
        end
    end

    // order the two planes and find which changed
    always_comb begin
        old1 = red_first ? i_red : i_green;
        new1 = red_first ? o_new_red : o_new_green;
        old2 = red_first ? i_green : i_red;
        new2 = red_first ? o_new_green : o_new_red;
        c1   = (old1 != new1);
        c2   = (old2 != new2);
    end

    // nibble writes: high nibble at the even address, low at the odd one
    always_comb begin
        p1[0] = '{chip_index: chip, ram_address: {red_first, i_item.column[3:0], 1'b0},
                  nibble: new1[7:4], last: 1'b0};
        p1[1] = '{chip_index: chip, ram_address: {red_first, i_item.column[3:0], 1'b1},
                  nibble: new1[3:0], last: !c2};
        p2[0] = '{chip_index: chip, ram_address: {!red_first, i_item.column[3:0], 1'b0},
                  nibble: new2[7:4], last: 1'b0};
        p2[1] = '{chip_index: chip, ram_address: {!red_first, i_item.column[3:0], 1'b1},
                  nibble: new2[3:0], last: 1'b1};
        o_res[0] = c1 ? p1[0] : p2[0];
        o_res[1] = c1 ? p1[1] : p2[1];
        o_res[2] = p2[0];
        o_res[3] = p2[1];
        o_count  = {c1 & c2, c1 ^ c2, 1'b0};
    end

endmodule

// ===== src/lms_result_buf.sv =====
// result buffer: holds the writes of one item and hands them out one a cycle when not stalled
module lms_result_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  lms_pkg::t_result i_res [4],
    input  logic [2:0]       i_count,
    output logic             o_free,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output lms_pkg::t_result o_res
);

    lms_pkg::t_result r_ent [4];
    logic [2:0]       r_left;
    logic [1:0]       r_idx;
    logic             take;

    // handshake and free signal for the next load
    always_comb begin
        o_out_valid = (r_left != 3'd0);
        take        = o_out_valid && !i_out_stall;
        o_free      = (r_left == 3'd0) || ((r_left == 3'd1) && take);
        o_res       = r_ent[r_idx];
    end

    // count of writes still to deliver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
            r_idx  <= 2'd0;
        end else if (i_load) begin
            r_left <= i_count;
            r_idx  <= 2'd0;
        end else if (take) begin
            r_left <= r_left - 3'd1;
            r_idx  <= r_idx + 2'd1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= i_res;
        end
    end

endmodule

// ===== tb/led_matrix_shadow_updater_checker.sv =====
// checker for the led matrix shadow updater: predicts nibble writes and compares them
`timescale 1ns / 1ps

module led_matrix_shadow_updater_checker #(
    parameter int COLUMNS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic       i_func,
    input  logic [4:0] i_column,
    input  logic [3:0] i_pixel_row,
    input  logic       i_band,
    input  logic [1:0] i_color,
    input  logic [7:0] i_column_bits,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [1:0] i_chip_index,
    input  logic [5:0] i_ram_address,
    input  logic [3:0] i_nibble,
    input  logic       i_last,
    output int         o_mismatch_count,
    output int         o_pending_count
);

    // color planes inside one column and band
    localparam logic PLANE_RED   = 1'b0;
    localparam logic PLANE_GREEN = 1'b1;

    // predicted display contents, indexed by column, band and plane
    logic [7:0] shadow_bytes [COLUMNS*4];

    // nibble writes still to come, oldest first
    lms_pkg::t_result pending_writes [$];

    // writes caused by the item being predicted
    lms_pkg::t_result item_writes [4];
    int               n_item_writes;

    int mismatch_count = 0;

    // store one color byte, queue its two nibble writes if it changes
    task automatic put_byte(input logic [4:0] col, input logic band, input logic plane,
                            input logic [7:0] value);
        int         idx;
        logic [1:0] chip;
        logic [5:0] addr;
        idx  = (int'(col) * 2 + int'(band)) * 2 + int'(plane);
        chip = {band, col[4]};
        addr = {plane == PLANE_RED, col[3:0], 1'b0};
        if (shadow_bytes[idx] != value) begin
            shadow_bytes[idx] = value;
            item_writes[n_item_writes]     = {chip, addr, value[7:4], 1'b0};
            item_writes[n_item_writes + 1] = {chip, addr | 6'd1, value[3:0], 1'b0};
            n_item_writes += 2;
        end
    endtask

    // work out every nibble write an accepted item causes
    task automatic predict_nibble_writes(input lms_pkg::t_func func, input logic [4:0] col,
                                         input logic [3:0] prow, input logic cband,
                                         input lms_pkg::t_color color,
                                         input logic [7:0] bits);
        logic       band;
        logic [7:0] mask;
        logic [7:0] red;
        logic [7:0] green;
        int         base;
        n_item_writes = 0;
        if (int'(col) < COLUMNS) begin
            if (func == lms_pkg::FUNC_PIXEL) begin
                band  = prow[3];
                mask  = lms_pkg::DOT_TOP >> prow[2:0];
                base  = (int'(col) * 2 + int'(band)) * 2;
                red   = shadow_bytes[base + int'(PLANE_RED)];
                green = shadow_bytes[base + int'(PLANE_GREEN)];
                case (color)
                    lms_pkg::COLOR_GREEN: begin
                        put_byte(col, band, PLANE_GREEN, green | mask);
                        put_byte(col, band, PLANE_RED, red & ~mask);
                    end
                    lms_pkg::COLOR_RED: begin
                        put_byte(col, band, PLANE_RED, red | mask);
                        put_byte(col, band, PLANE_GREEN, green & ~mask);
                    end
                    lms_pkg::COLOR_ORANGE: begin
                        put_byte(col, band, PLANE_GREEN, green | mask);
                        put_byte(col, band, PLANE_RED, red | mask);
                    end
                    default: begin
                        put_byte(col, band, PLANE_RED, red & ~mask);
                        put_byte(col, band, PLANE_GREEN, green & ~mask);
                    end
                endcase
            end else begin
                // a column write in black leaves the display alone
                case (color)
                    lms_pkg::COLOR_GREEN: begin
                        put_byte(col, cband, PLANE_GREEN, bits);
                        put_byte(col, cband, PLANE_RED, 8'h00);
                    end
                    lms_pkg::COLOR_RED: begin
                        put_byte(col, cband, PLANE_RED, bits);
                        put_byte(col, cband, PLANE_GREEN, 8'h00);
                    end
                    lms_pkg::COLOR_ORANGE: begin
                        put_byte(col, cband, PLANE_GREEN, bits);
                        put_byte(col, cband, PLANE_RED, bits);
                    end
                    default: ;
                endcase
            end
        end
        if (n_item_writes > 0)
            item_writes[n_item_writes - 1].last = 1'b1;
        for (int k = 0; k < n_item_writes; k++)
            pending_writes.push_back(item_writes[k]);
    endtask

    // watch both channels at every edge
    always @(posedge i_clk) begin
        lms_pkg::t_result got;
        lms_pkg::t_result want;
        if (!i_rst_n) begin
            foreach (shadow_bytes[i])
                shadow_bytes[i] = 8'h00;
            pending_writes.delete();
        end else begin
            // compare an accepted write with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                got = {i_chip_index, i_ram_address, i_nibble, i_last};
                if (pending_writes.size() == 0) begin
                    // fields shown as chip/addr/nibble/last
                    $display("%0t: expected none, actual %0d/%0d/%0d/%0b",
                             $time, got.chip_index, got.ram_address, got.nibble, got.last);
                    mismatch_count++;
                end else begin
                    want = pending_writes.pop_front();
                    if ((got.chip_index !== want.chip_index) ||
                        (got.ram_address !== want.ram_address) ||
                        (got.nibble !== want.nibble) || (got.last !== want.last)) begin
                        // fields shown as chip/addr/nibble/last
                        $display("%0t: expected %0d/%0d/%0d/%0b, actual %0d/%0d/%0d/%0b",
                                 $time, want.chip_index, want.ram_address, want.nibble,
                                 want.last, got.chip_index, got.ram_address, got.nibble,
                                 got.last);
                        mismatch_count++;
                    end
                end
            end
            // predict the writes of an accepted item
            if (i_in_valid && !i_in_stall)
                predict_nibble_writes(lms_pkg::t_func'(i_func), i_column, i_pixel_row,
                                      i_band, lms_pkg::t_color'(i_color), i_column_bits);
        end
        o_pending_count = pending_writes.size();
    end

    assign o_mismatch_count = mismatch_count;

endmodule

// ===== tb/led_matrix_shadow_updater_tb.sv =====
// testbench top for the led matrix shadow updater: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module led_matrix_shadow_updater_tb;

    localparam int COLUMNS        = 32;
    localparam int N_RANDOM       = 300;
    localparam int IDLE_LIMIT     = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLDOFF_START  = 400;
    localparam int HOLDOFF_CYCLES = 150;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic       in_func     = 1'b0;
    logic [4:0] in_column   = 5'd0;
    logic [3:0] in_pixel_row = 4'd0;
    logic       in_band     = 1'b0;
    logic [1:0] in_color    = 2'd0;
    logic [7:0] in_column_bits = 8'h00;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [1:0] out_chip_index;
    logic [5:0] out_ram_address;
    logic [3:0] out_nibble;
    logic       out_last;

    int mismatch_count;
    int pending_count;
    int burst_left  = 0;
    int idle_cycles = 0;

    always #10 clk = ~clk;

    led_matrix_shadow_updater #(
        .COLUMNS(COLUMNS)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_func       (in_func),
        .i_column     (in_column),
        .i_pixel_row  (in_pixel_row),
        .i_band       (in_band),
        .i_color      (in_color),
        .i_column_bits(in_column_bits),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_chip_index (out_chip_index),
        .o_ram_address(out_ram_address),
        .o_nibble     (out_nibble),
        .o_last       (out_last)
    );

    led_matrix_shadow_updater_checker #(
        .COLUMNS(COLUMNS)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_func          (in_func),
        .i_column        (in_column),
        .i_pixel_row     (in_pixel_row),
        .i_band          (in_band),
        .i_color         (in_color),
        .i_column_bits   (in_column_bits),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_chip_index    (out_chip_index),
        .i_ram_address   (out_ram_address),
        .i_nibble        (out_nibble),
        .i_last          (out_last),
        .o_mismatch_count(mismatch_count),
        .o_pending_count (pending_count)
    );

    // offer one item, opening a new burst after a random gap when the last one ran out
    task automatic send_item(input lms_pkg::t_func func, input logic [4:0] col,
                             input logic [3:0] prow, input logic band,
                             input lms_pkg::t_color color, input logic [7:0] bits);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_valid       <= 1'b1;
        in_func        <= func;
        in_column      <= col;
        in_pixel_row   <= prow;
        in_band        <= band;
        in_color       <= color;
        in_column_bits <= bits;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
    endtask

    // stimulus and verdict
    initial begin
        int              sent;
        lms_pkg::t_func  func;
        lms_pkg::t_color color;
        logic [7:0]      bits;
        sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // pixel writes: each color on one dot, a repeat that changes nothing, corner dots
        send_item(lms_pkg::FUNC_PIXEL, 5'd0, 4'd0, 1'b0, lms_pkg::COLOR_GREEN, 8'h00);
        send_item(lms_pkg::FUNC_PIXEL, 5'd0, 4'd0, 1'b1, lms_pkg::COLOR_GREEN, 8'hFF);
        send_item(lms_pkg::FUNC_PIXEL, 5'd0, 4'd0, 1'b0, lms_pkg::COLOR_RED, 8'h00);
        send_item(lms_pkg::FUNC_PIXEL, 5'd0, 4'd0, 1'b1, lms_pkg::COLOR_ORANGE, 8'hFF);
        send_item(lms_pkg::FUNC_PIXEL, 5'd0, 4'd0, 1'b0, lms_pkg::COLOR_BLACK, 8'h00);
        send_item(lms_pkg::FUNC_PIXEL, 5'd31, 4'd15, 1'b1, lms_pkg::COLOR_RED, 8'hFF);
        send_item(lms_pkg::FUNC_PIXEL, 5'd16, 4'd7, 1'b0, lms_pkg::COLOR_ORANGE, 8'h00);
        send_item(lms_pkg::FUNC_PIXEL, 5'd15, 4'd8, 1'b1, lms_pkg::COLOR_GREEN, 8'hFF);
        send_item(lms_pkg::FUNC_PIXEL, 5'd31, 4'd8, 1'b0, lms_pkg::COLOR_BLACK, 8'hFF);

        // column writes: every color, black ignored, repeats with no change
        send_item(lms_pkg::FUNC_COLUMN, 5'd0, 4'd0, 1'b0, lms_pkg::COLOR_GREEN, 8'hFF);
        send_item(lms_pkg::FUNC_COLUMN, 5'd0, 4'd15, 1'b0, lms_pkg::COLOR_GREEN, 8'hFF);
        send_item(lms_pkg::FUNC_COLUMN, 5'd0, 4'd0, 1'b0, lms_pkg::COLOR_RED, 8'hFF);
        send_item(lms_pkg::FUNC_COLUMN, 5'd0, 4'd15, 1'b0, lms_pkg::COLOR_ORANGE, 8'hFF);
        send_item(lms_pkg::FUNC_COLUMN, 5'd0, 4'd0, 1'b0, lms_pkg::COLOR_BLACK, 8'h00);
        send_item(lms_pkg::FUNC_COLUMN, 5'd31, 4'd0, 1'b1, lms_pkg::COLOR_RED, 8'h01);
        send_item(lms_pkg::FUNC_COLUMN, 5'd16, 4'd15, 1'b0, lms_pkg::COLOR_ORANGE, 8'hA5);
        send_item(lms_pkg::FUNC_COLUMN, 5'd15, 4'd0, 1'b1, lms_pkg::COLOR_GREEN, 8'h00);
        send_item(lms_pkg::FUNC_COLUMN, 5'd16, 4'd15, 1'b0, lms_pkg::COLOR_ORANGE, 8'h5A);
        send_item(lms_pkg::FUNC_COLUMN, 5'd31, 4'd15, 1'b1, lms_pkg::COLOR_BLACK, 8'hFF);
        send_item(lms_pkg::FUNC_COLUMN, 5'd7, 4'd0, 1'b1, lms_pkg::COLOR_GREEN, 8'h00);
        send_item(lms_pkg::FUNC_PIXEL, 5'd16, 4'd3, 1'b1, lms_pkg::COLOR_BLACK, 8'h00);
        send_item(lms_pkg::FUNC_COLUMN, 5'd0, 4'd0, 1'b0, lms_pkg::COLOR_ORANGE, 8'h00);

        // random items of every kind and color
        while (sent < N_RANDOM) begin
            func  = lms_pkg::t_func'($urandom_range(0, 1));
            color = lms_pkg::t_color'($urandom_range(0, 3));
            if ($urandom_range(0, 4) == 0)
                bits = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                bits = 8'($urandom);
            send_item(func, 5'($urandom_range(0, 31)), 4'($urandom), 1'($urandom), color, bits);
            sent++;
        end
        in_valid <= 1'b0;

        // let the last prediction land, wait for every write, then give the block time
        @(posedge clk);
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // receiver stalls in segments of random density, with one long hold-off
    initial begin
        int cycles;
        int seg_left;
        int stall_pct;
        cycles    = 0;
        seg_left  = 0;
        stall_pct = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles == HOLDOFF_START) begin
                out_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(20, 60);
                    case ($urandom_range(0, 2))
                        0: stall_pct = 0;
                        1: stall_pct = 30;
                        default: stall_pct = 75;
                    endcase
                end
                seg_left--;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // watchdog on cycles in which neither channel moves an item
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule
